/* design/bmpf_pkg.sv */
// shared types and constants of the bmp pixel stream to framebuffer block
// no dependencies
package bmpf_pkg;

  // screen and image limits
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int MAX_DIM       = 2048;

  // field and counter widths
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int CNT_W    = 12;
  localparam int POS_W    = CNT_W + 2;
  localparam int ADDR_W   = 19;
  localparam int COLOR_W  = 32;
  localparam int COL_W    = $clog2(SCREEN_WIDTH);
  localparam int ROW_W    = $clog2(SCREEN_HEIGHT);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd4;

  // byte phase codes
  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;
  localparam logic [1:0] PH_ALPHA = 2'd3;

  typedef struct packed {
    logic signed [12:0] image_width;
    logic signed [12:0] image_height;
    logic               has_alpha;
    logic signed [11:0] x_offset;
    logic signed [11:0] y_offset;
  } cfg_t;

  // one finished pixel with its unclipped screen position
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [COLOR_W-1:0]      color;
  } pix_t;

endpackage

/* design/bmpf_front.sv */
// front end: gathers bytes into pixels, skips row padding, tracks position
// depends on bmpf_pkg
module bmpf_front
  import bmpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] pixel_byte,
  input  logic       image_start,
  output logic       push,
  output pix_t       pix
);

  logic [1:0]       phase_r, phase_nxt, phase_c;
  logic [23:0]      acc_r, acc_nxt, acc_c;
  logic [CNT_W-1:0] col_r, col_nxt, col_c;
  logic [CNT_W-1:0] row_r, row_nxt, row_c;
  logic [1:0]       pad_r, pad_nxt, pad_c;
  logic [12:0]      wmag, hmag;
  logic [DIM_W-1:0] aw, ah;
  logic             w_pos, h_pos, emit;
  logic [COLOR_W-1:0] color_c;
  logic signed [POS_W-1:0] col_s, row_s, aw_s, ah_s, xo_s, yo_s;

  // saturated magnitudes of the image size
  always_comb begin
    wmag  = cfg.image_width[12] ? 13'(-cfg.image_width) : 13'(cfg.image_width);
    hmag  = cfg.image_height[12] ? 13'(-cfg.image_height) : 13'(cfg.image_height);
    aw    = (wmag > 13'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(wmag);
    ah    = (hmag > 13'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(hmag);
    w_pos = !cfg.image_width[12] && (cfg.image_width != 13'sd0);
    h_pos = !cfg.image_height[12] && (cfg.image_height != 13'sd0);
  end

  // counters seen by this byte, cleared by image_start
  always_comb begin
    phase_c = image_start ? PH_BLUE : phase_r;
    acc_c   = image_start ? '0 : acc_r;
    col_c   = image_start ? '0 : col_r;
    row_c   = image_start ? '0 : row_r;
    pad_c   = image_start ? '0 : pad_r;
  end

  // byte handling
  always_comb begin
    phase_nxt = phase_c;
    acc_nxt   = acc_c;
    col_nxt   = col_c;
    row_nxt   = row_c;
    pad_nxt   = pad_c;
    emit      = 1'b0;
    color_c   = '0;
    if (aw == '0 || ah == '0) begin
      emit = 1'b0;
    end else if (pad_c != 2'd0) begin
      pad_nxt = pad_c - 2'd1;
    end else if (13'(row_c) >= 13'(ah)) begin
      emit = 1'b0;
    end else if (phase_c == PH_BLUE || phase_c == PH_GREEN ||
                 (phase_c == PH_RED && cfg.has_alpha)) begin
      case (phase_c)
        PH_BLUE:  acc_nxt[7:0]   = acc_c[7:0] | pixel_byte;
        PH_GREEN: acc_nxt[15:8]  = acc_c[15:8] | pixel_byte;
        default:  acc_nxt[23:16] = acc_c[23:16] | pixel_byte;
      endcase
      phase_nxt = phase_c + 2'd1;
    end else begin
      emit = 1'b1;
      if (phase_c == PH_RED) begin
        color_c = {8'd0, acc_c[23:16] | pixel_byte, acc_c[15:0]};
      end else begin
        color_c = {pixel_byte, acc_c};
      end
      phase_nxt = PH_BLUE;
      acc_nxt   = '0;
      if (13'(col_c) >= 13'(aw) - 13'd1) begin
        col_nxt = '0;
        row_nxt = row_c + CNT_W'(1);
        pad_nxt = cfg.has_alpha ? 2'd0 : aw[1:0];
      end else begin
        col_nxt = col_c + CNT_W'(1);
      end
    end
  end

  // screen position with mirroring, flipping and offset
  always_comb begin
    col_s = POS_W'(col_c);
    row_s = POS_W'(row_c);
    aw_s  = POS_W'(aw);
    ah_s  = POS_W'(ah);
    xo_s  = POS_W'(cfg.x_offset);
    yo_s  = POS_W'(cfg.y_offset);
    pix.x = (w_pos ? col_s : aw_s - POS_W'(1) - col_s) + xo_s;
    pix.y = (h_pos ? ah_s - POS_W'(1) - row_s : row_s) + yo_s;
    pix.color = color_c;
  end

  assign push = accept && emit;

  // counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLUE;
      acc_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      pad_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

/* design/bmpf_fifo.sv */
// short pixel queue between the front and back ends
// depends on bmpf_pkg
module bmpf_fifo
  import bmpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pix_t push_data,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output pix_t pop_data
);

  pix_t               entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push, do_pop;

  assign not_full  = (count_r != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + (FIFO_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (FIFO_AW + 1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

/* design/bmpf_back.sv */
// back end: clips pixels to the screen and forms framebuffer writes
// depends on bmpf_pkg
module bmpf_back
  import bmpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pix_valid,
  input  pix_t                pix,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   out_address,
  output logic [COLOR_W-1:0]  out_color
);

  logic                valid_r;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [COLOR_W-1:0]  color_r;
  logic                on_screen, load;

  // take the next pixel once the output register is free
  assign load = !valid_r || out_ready;
  assign pop  = load && pix_valid;

  // clip test and word address
  always_comb begin
    on_screen = !pix.x[POS_W-1] && !pix.y[POS_W-1] &&
                (pix.x < POS_W'(SCREEN_WIDTH)) && (pix.y < POS_W'(SCREEN_HEIGHT));
    addr_nxt  = ADDR_W'(pix.y[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH)
              + ADDR_W'(pix.x[COL_W-1:0]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= pix_valid && on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r  <= addr_nxt;
      color_r <= pix.color;
    end
  end

  assign out_valid   = valid_r;
  assign out_address = addr_r;
  assign out_color   = color_r;

endmodule

/* design/bmp_pixel_stream_to_framebuffer.sv */
// bmp pixel array byte stream to argb framebuffer writes, top level
// depends on bmpf_pkg, bmpf_front, bmpf_fifo, bmpf_back
// throughput: one byte per cycle while the queue is not full; the 4-entry pixel queue absorbs output stalls
// path: a completing byte's write passes through the queue, then the output register
// reset: synchronous active-low rst_n clears counters, queue, output valid and
// all configuration registers; no clearing pass
module bmp_pixel_stream_to_framebuffer
  import bmpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // byte stream in
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // pixel_byte[7:0]
  input  logic                 in_tuser,   // image_start
  // framebuffer writes out
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata   // pixel_address[18:0], pixel_color[50:19]
);

  cfg_t               cfg_r;
  logic               accept, push, fifo_not_full, fifo_not_empty, pop;
  pix_t               push_pix, pop_pix;
  logic [ADDR_W-1:0]  address;
  logic [COLOR_W-1:0] color;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[12:0];
        REG_HAS_ALPHA:    cfg_r.has_alpha    <= cfg_data[0];
        REG_X_OFFSET:     cfg_r.x_offset     <= cfg_data[11:0];
        REG_Y_OFFSET:     cfg_r.y_offset     <= cfg_data[11:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // a byte is taken whenever the queue can hold a pixel
  assign in_tready = fifo_not_full;
  assign accept    = in_tvalid && in_tready;

  bmpf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .pixel_byte  (in_tdata),
    .image_start (in_tuser),
    .push        (push),
    .pix         (push_pix)
  );

  bmpf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_pix),
    .not_full  (fifo_not_full),
    .pop       (pop),
    .not_empty (fifo_not_empty),
    .pop_data  (pop_pix)
  );

  bmpf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (fifo_not_empty),
    .pix         (pop_pix),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_address (address),
    .out_color   (color)
  );

  assign out_tdata = {5'd0, color, address};

endmodule

/* design/bmpf_checker.sv */
// port-level checks for the bmp pixel stream to framebuffer block
// depends on bmpf_pkg; bound to bmp_pixel_stream_to_framebuffer
module bmpf_checker
  import bmpf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // a stalled write keeps its transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // every write lands inside the framebuffer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:0] < 19'(SCREEN_WIDTH * SCREEN_HEIGHT))
    else $error("framebuffer address out of range");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reset leaves the queue empty so input is taken at once
  assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind bmp_pixel_stream_to_framebuffer bmpf_checker u_bmpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
